// File: hw/rtl/sfta_pkg.sv
// shared types and op codes for the strip/fan triangle assembler
package sfta_pkg;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_VERTEX  = 2'd2;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    typedef struct packed {
        logic        [15:0] index;
        logic signed [15:0] s;
        logic signed [15:0] t;
    } vertex_t;

    typedef struct packed {
        logic        [1:0]  op;
        logic signed [15:0] word;
        vertex_t            vtx;
    } cmd_t;

    typedef struct packed {
        vertex_t     a;
        vertex_t     b;
        vertex_t     c;
        logic [15:0] number;
    } triangle_t;

    typedef struct packed {
        logic      produced;
        triangle_t triangle;
    } result_t;

endpackage

// File: hw/rtl/sfta_in_reg.sv
// input request register with stall generation
module sfta_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic        [1:0]  op,
    input  logic signed [15:0] command_word,
    input  logic        [15:0] vertex_index,
    input  logic signed [15:0] tex_s,
    input  logic signed [15:0] tex_t,
    input  logic               take,
    output logic               cmd_valid,
    output sfta_pkg::cmd_t     cmd
);

    logic           valid_reg;
    logic           valid_next;
    sfta_pkg::cmd_t cmd_reg;
    logic           accept;

    assign req_stall = valid_reg && !take;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op        <= op;
            cmd_reg.word      <= command_word;
            cmd_reg.vtx.index <= vertex_index;
            cmd_reg.vtx.s     <= tex_s;
            cmd_reg.vtx.t     <= tex_t;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: hw/rtl/sfta_assemble.sv
// primitive state, limit register and triangle corner selection
module sfta_assemble
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data,
    input  logic                take,
    input  sfta_pkg::cmd_t      cmd,
    output sfta_pkg::result_t   result
);

    logic [15:0]       limit_reg;
    logic [15:0]       left_reg, left_next;
    logic [15:0]       pos_reg, pos_next;
    logic              fan_reg, fan_next;
    sfta_pkg::vertex_t first_reg, first_next;
    sfta_pkg::vertex_t older_reg, older_next;
    sfta_pkg::vertex_t newer_reg, newer_next;
    logic [15:0]       count_reg, count_next;
    logic              vertex_live;
    logic              emit;

    assign vertex_live = (cmd.op == sfta_pkg::OP_VERTEX) && (left_reg != 16'd0);
    assign emit        = vertex_live && (pos_reg >= 16'd2) && (count_reg < limit_reg);

    // corner selection
    always_comb
    begin
        result.produced        = emit;
        result.triangle.c      = cmd.vtx;
        result.triangle.number = count_reg;
        if (fan_reg)
        begin
            result.triangle.a = first_reg;
            result.triangle.b = newer_reg;
        end
        else if (!pos_reg[0])
        begin
            result.triangle.a = older_reg;
            result.triangle.b = newer_reg;
        end
        else
        begin
            result.triangle.a = newer_reg;
            result.triangle.b = older_reg;
        end
    end

    always_comb
    begin
        left_next  = left_reg;
        pos_next   = pos_reg;
        fan_next   = fan_reg;
        first_next = first_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        if (take)
        begin
            case (cmd.op)
                sfta_pkg::OP_START:
                begin
                    count_next = 16'd0;
                    left_next  = 16'd0;
                    pos_next   = 16'd0;
                end
                sfta_pkg::OP_COMMAND:
                begin
                    pos_next = 16'd0;
                    if (cmd.word == 16'sd0)
                    begin
                        left_next = 16'd0;
                    end
                    else if (cmd.word[15])
                    begin
                        fan_next  = 1'b1;
                        left_next = 16'(~cmd.word) + 16'd1;
                    end
                    else
                    begin
                        fan_next  = 1'b0;
                        left_next = cmd.word;
                    end
                end
                sfta_pkg::OP_VERTEX:
                begin
                    if (vertex_live)
                    begin
                        if (pos_reg == 16'd0)
                        begin
                            first_next = cmd.vtx;
                        end
                        if (emit)
                        begin
                            count_next = count_reg + 16'd1;
                        end
                        older_next = newer_reg;
                        newer_next = cmd.vtx;
                        if (pos_reg != sfta_pkg::POS_MAX)
                        begin
                            pos_next = pos_reg + 16'd1;
                        end
                        left_next = left_reg - 16'd1;
                    end
                end
                default:
                begin
                    left_next = left_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= sfta_pkg::LIMIT_RESET;
            left_reg  <= 16'd0;
            pos_reg   <= 16'd0;
            fan_reg   <= 1'b0;
            first_reg <= '0;
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= 16'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            fan_reg   <= fan_next;
            first_reg <= first_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/sfta_out_reg.sv
// result register toward the triangle channel
module sfta_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  sfta_pkg::triangle_t  tri_in,
    input  logic                 res_stall,
    output logic                 res_valid,
    output logic                 free,
    output sfta_pkg::triangle_t  tri_out
);

    logic                valid_reg;
    logic                valid_next;
    sfta_pkg::triangle_t tri_reg;

    assign free = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tri_reg <= tri_in;
        end
    end

    assign res_valid = valid_reg;
    assign tri_out   = tri_reg;

endmodule

// File: hw/rtl/strip_fan_triangle_assembler.sv
// top level: strip and fan commands in, one triangle per qualifying vertex out
//
//   channel   handshake               payload
//   --------  ----------------------  -------------------------------------------
//   request   cmd_valid / cmd_stall   op, command_word, vertex_index, tex_s, tex_t
//   triangle  tri_valid / tri_stall   corner_*_index, corner_*_s/_t, triangle_number
//   config    cfg_valid / cfg_ready   cfg_data (triangle limit)
//
// one request per cycle sustained while tri_stall is low; a triangle leaves through
// the input register, then the result register; the primitive state is updated
// between them
// rst_n clears the handshake flags, the primitive state and sets the limit to 65535
// a stalled triangle holds the result register and the held request behind it,
// whether or not that request yields a triangle; with the input register full,
// cmd_stall rises
module strip_fan_triangle_assembler
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic        [1:0]  op,
    input  logic signed [15:0] command_word,
    input  logic        [15:0] vertex_index,
    input  logic signed [15:0] tex_s,
    input  logic signed [15:0] tex_t,

    output logic               tri_valid,
    input  logic               tri_stall,
    output logic        [15:0] corner_a_index,
    output logic        [15:0] corner_b_index,
    output logic        [15:0] corner_c_index,
    output logic signed [15:0] corner_a_s,
    output logic signed [15:0] corner_a_t,
    output logic signed [15:0] corner_b_s,
    output logic signed [15:0] corner_b_t,
    output logic signed [15:0] corner_c_s,
    output logic signed [15:0] corner_c_t,
    output logic        [15:0] triangle_number,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [15:0] cfg_data
);

    logic                held_valid;
    sfta_pkg::cmd_t      held_cmd;
    sfta_pkg::result_t   result;
    sfta_pkg::triangle_t tri_q;
    logic                out_free;
    logic                take;

    // a held request moves on whenever the result register can take a triangle
    assign take      = held_valid && out_free;
    // the limit register is always writable
    assign cfg_ready = 1'b1;

    sfta_in_reg u_in
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (cmd_valid),
        .req_stall    (cmd_stall),
        .op           (op),
        .command_word (command_word),
        .vertex_index (vertex_index),
        .tex_s        (tex_s),
        .tex_t        (tex_t),
        .take         (take),
        .cmd_valid    (held_valid),
        .cmd          (held_cmd)
    );

    sfta_assemble u_asm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .take      (take),
        .cmd       (held_cmd),
        .result    (result)
    );

    sfta_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && result.produced),
        .tri_in    (result.triangle),
        .res_stall (tri_stall),
        .res_valid (tri_valid),
        .free      (out_free),
        .tri_out   (tri_q)
    );

    // unpack the triangle
    assign corner_a_index  = tri_q.a.index;
    assign corner_a_s      = tri_q.a.s;
    assign corner_a_t      = tri_q.a.t;
    assign corner_b_index  = tri_q.b.index;
    assign corner_b_s      = tri_q.b.s;
    assign corner_b_t      = tri_q.b.t;
    assign corner_c_index  = tri_q.c.index;
    assign corner_c_s      = tri_q.c.s;
    assign corner_c_t      = tri_q.c.t;
    assign triangle_number = tri_q.number;

    // a triangle only comes from a vertex request
    assert property (@(posedge clk) disable iff (!rst_n)
        result.produced |-> held_cmd.op == sfta_pkg::OP_VERTEX)
        else $error("triangle produced from a non-vertex request");

    // third corner is the vertex that produced the triangle
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.produced) |=> (tri_valid && corner_c_index == $past(held_cmd.vtx.index)))
        else $error("third corner does not match the producing vertex");

    // a stalled result blocks the held request
    assert property (@(posedge clk) disable iff (!rst_n)
        (tri_valid && tri_stall) |-> !take)
        else $error("request advanced while result register is stalled");

    // the request side stalls only with a held request in place
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> held_valid)
        else $error("request stall with an empty input register");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for the strip/fan triangle assembler with its own triangle predictor
module testbench;

    // op value that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one row of the directed table; typed rows carry a hand-written expectation
    typedef struct {
        sfta_pkg::cmd_t      req;
        bit                  typed;
        bit                  made;
        sfta_pkg::triangle_t shape;
    } step_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic        [1:0]  op = sfta_pkg::OP_START;
    logic signed [15:0] command_word = '0;
    logic        [15:0] vertex_index = '0;
    logic signed [15:0] tex_s = '0;
    logic signed [15:0] tex_t = '0;

    logic               tri_valid;
    logic               tri_stall = 1'b0;
    logic        [15:0] corner_a_index;
    logic        [15:0] corner_b_index;
    logic        [15:0] corner_c_index;
    logic signed [15:0] corner_a_s;
    logic signed [15:0] corner_a_t;
    logic signed [15:0] corner_b_s;
    logic signed [15:0] corner_b_t;
    logic signed [15:0] corner_c_s;
    logic signed [15:0] corner_c_t;
    logic        [15:0] triangle_number;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [15:0] cfg_data = '0;

    strip_fan_triangle_assembler i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .op              (op),
        .command_word    (command_word),
        .vertex_index    (vertex_index),
        .tex_s           (tex_s),
        .tex_t           (tex_t),
        .tri_valid       (tri_valid),
        .tri_stall       (tri_stall),
        .corner_a_index  (corner_a_index),
        .corner_b_index  (corner_b_index),
        .corner_c_index  (corner_c_index),
        .corner_a_s      (corner_a_s),
        .corner_a_t      (corner_a_t),
        .corner_b_s      (corner_b_s),
        .corner_b_t      (corner_b_t),
        .corner_c_s      (corner_c_s),
        .corner_c_t      (corner_c_t),
        .triangle_number (triangle_number),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state: mirrors the primitive tracking inside the block
    int unsigned          left_in_prim;
    logic [15:0]          prim_pos;
    bit                   prim_fan;
    sfta_pkg::vertex_t    first_corner;
    sfta_pkg::vertex_t    older_corner;
    sfta_pkg::vertex_t    newer_corner;
    logic [15:0]          tri_count;
    logic [15:0]          tri_limit;

    // triangles predicted but not yet seen on the output
    sfta_pkg::triangle_t  pending_triangles[$];
    step_row_t            directed_steps[$];

    int           mismatches = 0;
    int           triangles_checked = 0;
    int           requests_used = 0;

    // idling controls for the request side and the triangle side
    bit           quiet_in = 1'b0;
    bit           quiet_out = 1'b0;
    bit           hold_asked = 1'b0;
    bit           hold_done = 1'b0;
    int           stall_left = 0;

    string field_names[10] = '{"corner_a_index", "corner_b_index", "corner_c_index",
                               "corner_a_s", "corner_a_t", "corner_b_s", "corner_b_t",
                               "corner_c_s", "corner_c_t", "triangle_number"};

    // assemble one request into at most one triangle, advancing the predictor state
    function automatic bit assemble_triangle(input sfta_pkg::cmd_t req,
                                             output sfta_pkg::triangle_t shape);
        sfta_pkg::vertex_t a;
        sfta_pkg::vertex_t b;
        logic [31:0]       mag;
        bit                made;
        made = 1'b0;
        shape = '0;
        case (req.op)
            sfta_pkg::OP_START:
            begin
                tri_count = '0;
                left_in_prim = 0;
                prim_pos = '0;
            end
            sfta_pkg::OP_COMMAND:
            begin
                prim_pos = '0;
                mag = {16'h0000, req.word};
                if (req.word == 16'sd0)
                begin
                    left_in_prim = 0;
                end
                else if (req.word[15])
                begin
                    // fan: magnitude of the negative word, -32768 gives 32768
                    prim_fan = 1'b1;
                    left_in_prim = 32'h0001_0000 - mag;
                end
                else
                begin
                    prim_fan = 1'b0;
                    left_in_prim = mag;
                end
            end
            sfta_pkg::OP_VERTEX:
            begin
                if (left_in_prim != 0)
                begin
                    if (prim_pos == 16'd0)
                        first_corner = req.vtx;
                    if (prim_pos >= 16'd2)
                    begin
                        if (prim_fan)
                        begin
                            a = first_corner;
                            b = newer_corner;
                        end
                        else if (!prim_pos[0])
                        begin
                            a = older_corner;
                            b = newer_corner;
                        end
                        else
                        begin
                            // odd strip position flips the winding
                            a = newer_corner;
                            b = older_corner;
                        end
                        if (tri_count < tri_limit)
                        begin
                            shape.a = a;
                            shape.b = b;
                            shape.c = req.vtx;
                            shape.number = tri_count;
                            tri_count = tri_count + 16'd1;
                            made = 1'b1;
                        end
                    end
                    older_corner = newer_corner;
                    newer_corner = req.vtx;
                    if (prim_pos != sfta_pkg::POS_MAX)
                        prim_pos = prim_pos + 16'd1;
                    left_in_prim = left_in_prim - 1;
                end
            end
            default:
            begin
            end
        endcase
        return made;
    endfunction

    function automatic sfta_pkg::vertex_t vtx(input logic [15:0] index,
                                              input logic [15:0] s,
                                              input logic [15:0] t);
        sfta_pkg::vertex_t v;
        v.index = index;
        v.s = s;
        v.t = t;
        return v;
    endfunction

    function automatic sfta_pkg::cmd_t request_of(input logic [1:0] kind,
                                                  input logic [15:0] word,
                                                  input sfta_pkg::vertex_t v);
        sfta_pkg::cmd_t req;
        req.op = kind;
        req.word = word;
        req.vtx = v;
        return req;
    endfunction

    // every field random, op as given
    function automatic sfta_pkg::cmd_t random_request(input logic [1:0] kind);
        return request_of(kind, 16'($urandom),
                          vtx(16'($urandom), 16'($urandom), 16'($urandom)));
    endfunction

    task automatic add_step(input sfta_pkg::cmd_t req, input bit typed = 1'b0,
                            input bit made = 1'b0,
                            input sfta_pkg::triangle_t shape = '0);
        step_row_t row;
        row.req = req;
        row.typed = typed;
        row.made = made;
        row.shape = shape;
        directed_steps.push_back(row);
    endtask

    // offer one request, wait for acceptance, then predict and maybe idle
    task automatic send_request(input sfta_pkg::cmd_t req, input bit typed,
                                input bit made_want, input sfta_pkg::triangle_t want);
        sfta_pkg::triangle_t shape;
        bit                  made;
        int                  gap;
        int                  r;
        cmd_valid <= 1'b1;
        op <= req.op;
        command_word <= req.word;
        vertex_index <= req.vtx.index;
        tex_s <= req.vtx.s;
        tex_t <= req.vtx.t;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // ignored requests (unused op, vertex outside a primitive) are not counted
        if (req.op == sfta_pkg::OP_START || req.op == sfta_pkg::OP_COMMAND ||
            (req.op == sfta_pkg::OP_VERTEX && left_in_prim != 0))
            requests_used++;
        made = assemble_triangle(req, shape);
        if (typed)
        begin
            made = made_want;
            shape = want;
        end
        if (made)
            pending_triangles.push_back(shape);
        gap = 0;
        if (!quiet_in)
        begin
            r = $urandom_range(0, 99);
            if (r >= 97)
                gap = $urandom_range(10, 40);
            else if (r >= 75)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering requests until every predicted triangle has come out
    task automatic drain_triangles();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_triangles.size() != 0)
            @(posedge clk);
        // requests without a triangle may still sit in the input register
        repeat (6) @(posedge clk);
    endtask

    task automatic set_triangle_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tri_limit = value;
    endtask

    // mostly well-formed primitives with random content, plus noise and broken ones
    task automatic random_phase(input int target);
        int             first_count;
        int             r;
        int             mag;
        int             sends;
        bit             fan;
        sfta_pkg::cmd_t req;
        first_count = requests_used;
        while (requests_used - first_count < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                send_request(random_request(sfta_pkg::OP_START), 1'b0, 1'b0, '0);
            end
            else if (r < 16)
            begin
                req = random_request(sfta_pkg::OP_COMMAND);
                req.word = 16'sd0;
                send_request(req, 1'b0, 1'b0, '0);
            end
            else if (r < 20)
            begin
                send_request(random_request(OP_UNUSED), 1'b0, 1'b0, '0);
            end
            else if (r < 23)
            begin
                send_request(random_request(sfta_pkg::OP_VERTEX), 1'b0, 1'b0, '0);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    mag = $urandom_range(1, 12);
                else if (r < 95)
                    mag = $urandom_range(13, 40);
                else
                    mag = $urandom_range(41, 32768);
                fan = 1'($urandom_range(0, 1));
                if (!fan && mag > 32767)
                    mag = 32767;
                // long primitives get only a few vertices before being cut off
                sends = (mag > 40) ? $urandom_range(0, 8) : mag;
                r = $urandom_range(0, 99);
                if (r < 10)
                    sends = $urandom_range(0, sends);
                else if (r < 15)
                    sends = sends + $urandom_range(1, 2);
                req = random_request(sfta_pkg::OP_COMMAND);
                req.word = fan ? 16'(-mag) : 16'(mag);
                send_request(req, 1'b0, 1'b0, '0);
                for (int i = 0; i < sends; i++)
                    send_request(random_request(sfta_pkg::OP_VERTEX), 1'b0, 1'b0, '0);
            end
        end
    endtask

    // compare one accepted triangle with the oldest prediction
    task automatic check_triangle();
        sfta_pkg::triangle_t w;
        logic [15:0]         got[10];
        logic [15:0]         want[10];
        if (pending_triangles.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected triangle %0d (%0d,%0d,%0d) with nothing pending",
                         triangle_number, corner_a_index, corner_b_index, corner_c_index);
        end
        else
        begin
            w = pending_triangles.pop_front();
            triangles_checked++;
            got = '{corner_a_index, corner_b_index, corner_c_index, corner_a_s, corner_a_t,
                    corner_b_s, corner_b_t, corner_c_s, corner_c_t, triangle_number};
            want = '{w.a.index, w.b.index, w.c.index, w.a.s, w.a.t,
                     w.b.s, w.b.t, w.c.s, w.c.t, w.number};
            for (int i = 0; i < 10; i++)
            begin
                if (got[i] !== want[i])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("triangle %0d field %s: expected %h got %h",
                                 triangles_checked, field_names[i], want[i], got[i]);
                end
            end
        end
    endtask

    // triangle side: check accepted results, then pick the next stall value
    always @(posedge clk)
    begin
        if (tri_valid && !tri_stall)
            check_triangle();
        // one long hold-off so the pipeline fills and pushes back on requests
        if (hold_asked && !hold_done)
        begin
            stall_left = 90;
            hold_done = 1'b1;
        end
        if (stall_left == 0 && !quiet_out)
        begin
            if ($urandom_range(0, 99) >= 97)
                stall_left = $urandom_range(10, 30);
            else if ($urandom_range(0, 99) >= 78)
                stall_left = $urandom_range(1, 3);
        end
        if (stall_left > 0)
        begin
            tri_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            tri_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        sfta_pkg::vertex_t va;
        sfta_pkg::vertex_t vb;
        sfta_pkg::vertex_t vc;
        logic [15:0]       phase_limit[5];
        int                phase_items[5];

        left_in_prim = 0;
        prim_pos = '0;
        prim_fan = 1'b0;
        first_corner = '0;
        older_corner = '0;
        newer_corner = '0;
        tri_count = '0;
        tri_limit = sfta_pkg::LIMIT_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: field extremes, both primitive kinds and each corner case
        va = vtx(16'h0000, 16'h8000, 16'h7FFF);
        vb = vtx(16'hFFFF, 16'h7FFF, 16'h8000);
        vc = vtx(16'h5A5A, 16'hFFFF, 16'h0001);
        add_step(request_of(sfta_pkg::OP_START, 16'h0000, '0), 1'b1, 1'b0);
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'd3, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, va));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vb));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vc), 1'b1, 1'b1,
                 sfta_pkg::triangle_t'{va, vb, vc, 16'd0});
        // stray vertex after the strip is used up
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000,
                            vtx(16'h1111, 16'h0100, 16'h0200)),
                 1'b1, 1'b0);
        add_step(request_of(OP_UNUSED, 16'hFFFF, vtx(16'hFFFF, 16'hFFFF, 16'hFFFF)),
                 1'b1, 1'b0);
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'hFFFC, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd20, 16'h0180, 16'hFF80)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd21, 16'h0280, 16'hFE80)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd22, 16'h0380, 16'hFD80)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd23, 16'h0480, 16'hFC80)));
        // counts of one and two consume vertices without a triangle
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'd1, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd30, 16'h0010, 16'h0020)));
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'd2, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd31, 16'h0030, 16'h0040)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd32, 16'h0050, 16'h0060)));
        // zero command closes an open strip, the next vertex is stray
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'd5, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd40, 16'h1000, 16'h2000)));
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'h0000, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd41, 16'h3000, 16'h4000)));
        // most negative word opens a fan of 32768, then a strip abandons it
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'h8000, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd50, 16'hC000, 16'h4000)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd51, 16'hC100, 16'h4100)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd52, 16'hC200, 16'h4200)));
        add_step(request_of(sfta_pkg::OP_COMMAND, 16'd4, '0));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd60, 16'h0001, 16'h0002)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd61, 16'h0003, 16'h0004)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd62, 16'h0005, 16'h0006)));
        add_step(request_of(sfta_pkg::OP_VERTEX, 16'h0000, vtx(16'd63, 16'h0007, 16'h0008)));

        foreach (directed_steps[i])
            send_request(directed_steps[i].req, directed_steps[i].typed,
                         directed_steps[i].made, directed_steps[i].shape);

        // random phases, each under its own limit; limit 0 and 65535 among them
        phase_limit[0] = 16'd0;
        phase_limit[1] = 16'd1;
        phase_limit[2] = 16'($urandom_range(2, 30));
        phase_limit[3] = 16'hFFFF;
        phase_limit[4] = 16'($urandom_range(3, 12));
        phase_items = '{80, 80, 100, 120, 100};
        for (int p = 0; p < 5; p++)
        begin
            drain_triangles();
            set_triangle_limit(phase_limit[p]);
            // first phase runs without idling, third one pushes the pipeline full
            quiet_in = (p == 0) || (p == 2);
            quiet_out = (p == 0);
            hold_asked = (p == 2);
            random_phase(phase_items[p]);
        end
        drain_triangles();
        repeat (10) @(posedge clk);

        $display("run: %0d directed rows and %0d counted requests over 5 limit settings",
                 directed_steps.size(), requests_used);
        $display("run: %0d triangles compared, %0d field mismatches",
                 triangles_checked, mismatches);
        if (mismatches == 0 && pending_triangles.size() == 0)
            $display("[strip_fan_triangle_assembler] OK");
        else
            $display("[strip_fan_triangle_assembler] ERROR");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d triangles still pending", pending_triangles.size());
        $display("[strip_fan_triangle_assembler] ERROR");
        $finish;
    end

endmodule
